// ----- hdl/cdad_pkg.sv -----
`default_nettype none
package cdad_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned OFF_W   = 17;
	// working day count: start day plus offset, signed
	localparam int unsigned WD_W    = 18;
	// working year: may run below one or past the 14-bit field
	localparam int unsigned WY_W    = 18;
	// year modulo 400
	localparam int unsigned R_W     = 9;

	localparam logic [R_W-1:0]     CYCLE_LAST  = 9'd399;
	localparam logic [8:0]         YEAR_DAYS   = 9'd365;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_WRAP  = 4'd13;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_in;
		logic [MONTH_W-1:0] month_in;
		logic [DAY_W-1:0]   day_in;
		logic [OFF_W-1:0]   offset_days;
	} date_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year_out;
		logic [MONTH_W-1:0] month_out;
		logic [DAY_W-1:0]   day_out;
		logic               input_invalid;
		logic               year_out_of_range;
	} date_res_t;

	typedef struct packed {
		logic load;
		logic mod_step;
		logic check;
		logic run_step;
		logic out_load;
	} cdad_cmd_t;

	typedef struct packed {
		logic mod_last;
		logic run_done;
	} cdad_stat_t;

	// leap test on the year modulo 400
	function automatic logic leap_of(input logic [R_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
	                                              input logic leap);
		logic [DAY_W-1:0] n;
		unique case (m) inside
			4'd2:                     n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
			default:                  n = 5'd31;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/calendar_date_add_days.sv -----
// Sequence: reduce the year modulo 400 by subtracting shifted multiples of 400, check
// the date and add the offset, then step by whole years and single months until the day
// fits its month, then load the result register once the output side is free.
// Throughput: one request at a time; the next is taken the cycle after the result is
// loaded.
// Reset: arst_n clears the controller and result valid; payload registers are not reset.
`default_nettype none
module calendar_date_add_days #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  date_valid,
	output logic                 date_ready,
	input  cdad_pkg::date_req_t  date,
	output logic                 result_valid,
	input  wire                  result_ready,
	output cdad_pkg::date_res_t  result
);
	import cdad_pkg::*;

	// Controller sequences: accept, modulo reduction, validity check, carry loop,
	// then hands the result to the output register. The datapath never stalls the
	// loop on the output side until the last step, so a new request is taken while
	// the previous result still waits.
	cdad_cmd_t  cmd;
	cdad_stat_t stat;

	cdad_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.date_valid   (date_valid),
		.date_ready   (date_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.stat         (stat)
	);

	// Datapath: year kept signed so borrows below year one stay exact; the leap test
	// runs off a running year-modulo-400 count rather than any division. Whole years
	// are jumped while the day count covers a full twelve-month span.
	cdad_dp #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk  (clk),
		.req  (date),
		.cmd  (cmd),
		.stat (stat),
		.res  (result)
	);

endmodule
`default_nettype wire

// ----- hdl/cdad_ctrl.sv -----
`default_nettype none
module cdad_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    date_valid,
	output logic                   date_ready,
	output logic                   result_valid,
	input  wire                    result_ready,
	output cdad_pkg::cdad_cmd_t    cmd,
	input  cdad_pkg::cdad_stat_t   stat
);
	import cdad_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_CHECK,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free   = !result_valid || result_ready;
	assign date_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && date_valid;
		cmd.mod_step = (state_q == ST_MOD);
		cmd.check    = (state_q == ST_CHECK);
		cmd.run_step = (state_q == ST_RUN) && !stat.run_done;
		cmd.out_load = (state_q == ST_RUN) && stat.run_done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			result_valid <= 1'b0;
		end else begin
			if (cmd.out_load)
				result_valid <= 1'b1;
			else if (result_ready)
				result_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (date_valid) state_q <= ST_MOD;
				ST_MOD:   if (stat.mod_last) state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_RUN;
				ST_RUN:   if (cmd.out_load) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cdad_dp.sv -----
`default_nettype none
module cdad_dp #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  wire                    clk,
	input  cdad_pkg::date_req_t    req,
	input  cdad_pkg::cdad_cmd_t    cmd,
	output cdad_pkg::cdad_stat_t   stat,
	output cdad_pkg::date_res_t    res
);
	import cdad_pkg::*;

	localparam logic signed [WY_W-1:0] MAXY = WY_W'(MAX_YEAR);

	logic signed [WY_W-1:0]  y_q;
	logic [MONTH_W-1:0]      m_q;
	logic signed [WD_W-1:0]  d_q;
	logic [YEAR_W-1:0]       r_q;
	logic [2:0]              k_q;
	logic [OFF_W-1:0]        off_q;
	logic                    fwd_q;
	logic                    bad_q;

	logic [R_W-1:0]          r, r_inc, r_dec;
	logic                    lp, lp_inc, lp_dec;
	logic [YEAR_W:0]         mod_thr;
	logic [DAY_W-1:0]        dim_cur, dim_prev;
	logic [MONTH_W-1:0]      m_prev;
	logic [8:0]              ylen_f, ylen_b;
	logic signed [WD_W-1:0]  sum_b, off_x;
	logic                    yr_step_f, yr_step_b, mon_step_f, mon_step_b;
	logic                    bad;

	assign r      = r_q[R_W-1:0];
	assign r_inc  = (r == CYCLE_LAST) ? '0 : r + 1'b1;
	assign r_dec  = (r == '0) ? CYCLE_LAST : r - 1'b1;
	assign lp     = leap_of(r);
	assign lp_inc = leap_of(r_inc);
	assign lp_dec = leap_of(r_dec);

	assign mod_thr = (YEAR_W+1)'(400) << k_q;

	assign dim_cur  = month_days(m_q, lp);
	assign m_prev   = (m_q == 4'd1) ? MONTH_DEC : m_q - 1'b1;
	assign dim_prev = month_days(m_prev, (m_q == 4'd1) ? lp_dec : lp);

	// span of twelve months ahead holds February of this year or the next
	assign ylen_f = YEAR_DAYS + 9'((m_q <= MONTH_FEB) ? lp : lp_inc);
	// span of twelve months behind holds February of this year or the last
	assign ylen_b = YEAR_DAYS + 9'((m_q >= MONTH_MAR) ? lp : lp_dec);
	assign sum_b  = d_q + $signed({{(WD_W-9){1'b0}}, ylen_b});

	assign yr_step_f  = d_q > $signed({{(WD_W-9){1'b0}}, ylen_f});
	assign mon_step_f = d_q > $signed({{(WD_W-DAY_W){1'b0}}, dim_cur});
	assign yr_step_b  = sum_b <= 0;
	assign mon_step_b = d_q <= 0;

	assign off_x = {off_q[OFF_W-1], off_q};

	assign bad = (y_q == '0) || (y_q > MAXY) || (m_q == '0) || (m_q > MONTH_DEC) ||
	             (d_q == '0) || (d_q > $signed({{(WD_W-DAY_W){1'b0}}, dim_cur}));

	assign stat.mod_last = (k_q == '0);
	assign stat.run_done = fwd_q ? !mon_step_f : !mon_step_b;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q   <= {{(WY_W-YEAR_W){1'b0}}, req.year_in};
			m_q   <= req.month_in;
			d_q   <= {{(WD_W-DAY_W){1'b0}}, req.day_in};
			r_q   <= req.year_in;
			off_q <= req.offset_days;
			k_q   <= 3'd5;
		end
		if (cmd.mod_step) begin
			if ({1'b0, r_q} >= mod_thr)
				r_q <= r_q - mod_thr[YEAR_W-1:0];
			k_q <= k_q - 1'b1;
		end
		if (cmd.check) begin
			bad_q <= bad;
			fwd_q <= !off_q[OFF_W-1];
			if (bad) begin
				y_q <= WY_W'(1);
				m_q <= 4'd1;
				r_q <= YEAR_W'(1);
				d_q <= off_x + WD_W'(1);
			end else begin
				d_q <= d_q + off_x;
			end
		end
		if (cmd.run_step) begin
			if (fwd_q) begin
				if (yr_step_f) begin
					d_q <= d_q - $signed({{(WD_W-9){1'b0}}, ylen_f});
					y_q <= y_q + 1'b1;
					r_q <= {{(YEAR_W-R_W){1'b0}}, r_inc};
				end else begin
					d_q <= d_q - $signed({{(WD_W-DAY_W){1'b0}}, dim_cur});
					if (m_q + 1'b1 == MONTH_WRAP) begin
						m_q <= 4'd1;
						y_q <= y_q + 1'b1;
						r_q <= {{(YEAR_W-R_W){1'b0}}, r_inc};
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
			end else begin
				if (yr_step_b) begin
					d_q <= sum_b;
					y_q <= y_q - 1'b1;
					r_q <= {{(YEAR_W-R_W){1'b0}}, r_dec};
				end else begin
					d_q <= d_q + $signed({{(WD_W-DAY_W){1'b0}}, dim_prev});
					m_q <= m_prev;
					if (m_q == 4'd1) begin
						y_q <= y_q - 1'b1;
						r_q <= {{(YEAR_W-R_W){1'b0}}, r_dec};
					end
				end
			end
		end
		if (cmd.out_load) begin
			res.year_out          <= (y_q < 1) ? '0 : y_q[YEAR_W-1:0];
			res.month_out         <= m_q;
			res.day_out           <= d_q[DAY_W-1:0];
			res.input_invalid     <= bad_q;
			res.year_out_of_range <= (y_q < 1) || (y_q > MAXY);
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cdad_checker.sv -----
`default_nettype none
module cdad_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  date_valid,
	input wire                  date_ready,
	input cdad_pkg::date_req_t  date,
	input wire                  result_valid,
	input wire                  result_ready,
	input cdad_pkg::date_res_t  result
);
	import cdad_pkg::*;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		date_valid && !date_ready |=> date_valid && $stable(date))
		else $error("request dropped or changed while waiting");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.month_out >= 4'd1) && (result.month_out <= MONTH_DEC))
		else $error("month out of range");

	a_day_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.day_out != '0))
		else $error("day zero");

	a_year_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.year_out_of_range |-> (result.year_out != '0))
		else $error("year zero without range flag");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (.*);
`default_nettype wire
